/* rtl/ipcmq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipcmq_pkg: shared types and constants of the mailbox queue engine
// Command codes, status codes, sizes and the item payload types.
// ----------------------------------------------------------------------------
package ipcmq_pkg;

    localparam int NUM_QUEUES = 8;
    localparam int MSG_DEPTH  = 16;
    localparam int WAIT_DEPTH = 8;

    localparam int QW = $clog2(NUM_QUEUES);
    localparam int MW = $clog2(MSG_DEPTH);
    localparam int WW = $clog2(WAIT_DEPTH);

    typedef enum logic [2:0] {
        K_CREATE    = 3'd0,
        K_SEND      = 3'd1,
        K_RECV      = 3'd2,
        K_ADD_SEND  = 3'd3,
        K_ADD_RECV  = 3'd4,
        K_POP_SEND  = 3'd5,
        K_POP_RECV  = 3'd6,
        K_GRANT_QRY = 3'd7
    } t_kind;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BLOCK = 2'd1;
    localparam logic [1:0] ST_ERR   = 2'd2;

    typedef struct packed {
        logic [2:0]         kind;
        logic [15:0]        queue_key;
        logic [7:0]         task_id;
        logic signed [31:0] payload;
    } t_cmd;

    typedef struct packed {
        logic [1:0]         status;
        logic [7:0]         msg_sender;
        logic signed [31:0] msg_payload;
        logic               waiter_valid;
        logic [7:0]         waiter_id;
        logic               grant_present;
    } t_rsp;

endpackage

/* rtl/ipcmq_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipcmq_cmd_if / ipcmq_rsp_if: valid/ready channels of the mailbox engine
// One item moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
interface ipcmq_cmd_if;
    logic            valid;
    logic            ready;
    ipcmq_pkg::t_cmd data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ipcmq_rsp_if;
    logic            valid;
    logic            ready;
    ipcmq_pkg::t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/ipc_mailbox_queue_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_mailbox_queue_engine: mailbox engine with waiter and grant lists
// Table of message queues found by a 16-bit key, worked by a sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries one command (kind, queue_key, task_id, payload); o_rsp
//   returns exactly one result item per command, in order.
//   One index counter walks the queue table (one slot a cycle); a second
//   walks the grant or waiter list (registered read, then compare), and a
//   compaction pass shifts a list down one entry at a time.
//   One command at a time: i_cmd.ready is high only while idle, so a new
//   command is taken only after the previous result has been taken.
//   The result sits in an output register; a stalled receiver holds it and
//   the engine takes no new command until it is taken.
//   Reset clears the slot table and all counts; the message, waiter and
//   grant stores are used only below their counts and are not cleared.
// ----------------------------------------------------------------------------
module ipc_mailbox_queue_engine (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ipcmq_cmd_if.sink      i_cmd,
    ipcmq_rsp_if.source    o_rsp
);
    localparam int QW = ipcmq_pkg::QW;
    localparam int MW = ipcmq_pkg::MW;
    localparam int WW = ipcmq_pkg::WW;
    localparam int NQ = ipcmq_pkg::NUM_QUEUES;
    localparam int WD = ipcmq_pkg::WAIT_DEPTH;
    localparam int MD = ipcmq_pkg::MSG_DEPTH;
    localparam int LW = QW + WW;
    localparam int SW = QW + MW;

    typedef enum logic [3:0] {
        S_IDLE, S_LOOK, S_DISPATCH, S_SCAN, S_CHK, S_RD, S_RD2,
        S_SHIFT, S_SHIFT_WR, S_SHIFT2, S_RSP
    } t_state;

    // list selector for the shared scan and shift unit
    typedef enum logic [1:0] { L_RECV, L_SEND, L_GRANT } t_list;

    t_state r_state;
    ipcmq_pkg::t_cmd r_cmd;
    ipcmq_pkg::t_rsp r_rsp;

    logic              r_used  [NQ];
    logic [15:0]       r_key   [NQ];
    logic [MW-1:0]     r_head  [NQ];
    logic [MW:0]       r_rcnt  [NQ];
    logic [WW:0]       r_wrcnt [NQ];
    logic [WW:0]       r_wscnt [NQ];
    logic [WW:0]       r_gcnt  [NQ];

    logic [39:0] r_msg   [NQ*MD];
    logic [7:0]  r_rlist [NQ*WD];
    logic [7:0]  r_slist [NQ*WD];
    logic [7:0]  r_gown  [NQ*WD];
    logic [39:0] r_gmsg  [NQ*WD];

    logic [QW:0]   r_idx;
    logic [QW-1:0] r_q;
    logic          r_hit;
    logic          r_free_ok;
    logic [QW-1:0] r_free;
    logic [WW:0]   r_i;
    t_list         r_list;
    logic          r_found;
    logic [7:0]    r_rd_id;
    logic [39:0]   r_rd_msg;
    logic [7:0]    r_rd_r0;
    logic [39:0]   r_rd_ring;
    logic          r_then_rm;
    logic          r_rm;

    logic [QW-1:0] w_idx;
    logic [WW-1:0] w_i;
    logic [LW-1:0] w_la;
    logic [LW-1:0] w_lb;
    logic [WW:0]   w_cnt;
    logic [LW-1:0] w_q0;

    assign w_idx = r_idx[QW-1:0];
    assign w_i   = r_i[WW-1:0];
    assign w_la  = {r_q, w_i};
    assign w_lb  = w_la + LW'(1);
    assign w_q0  = {r_q, WW'(0)};

    always_comb begin
        case (r_list)
            L_RECV:  w_cnt = r_wrcnt[r_q];
            L_SEND:  w_cnt = r_wscnt[r_q];
            default: w_cnt = r_gcnt[r_q];
        endcase
    end

    assign i_cmd.ready = (r_state == S_IDLE);
    assign o_rsp.valid = (r_state == S_RSP);
    assign o_rsp.data  = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int k = 0; k < NQ; k++) begin
                r_used[k]  <= 1'b0;
                r_key[k]   <= '0;
                r_head[k]  <= '0;
                r_rcnt[k]  <= '0;
                r_wrcnt[k] <= '0;
                r_wscnt[k] <= '0;
                r_gcnt[k]  <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_cmd     <= i_cmd.data;
                        r_rsp     <= '0;
                        r_idx     <= '0;
                        r_hit     <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_rm      <= 1'b0;
                        r_state   <= S_LOOK;
                    end
                end
                // walk the slot table: one compare a cycle
                S_LOOK: begin
                    if (r_idx == (QW+1)'(NQ)) begin
                        r_state <= S_DISPATCH;
                    end else begin
                        if (r_used[w_idx] && r_key[w_idx] == r_cmd.queue_key && !r_hit) begin
                            r_hit <= 1'b1;
                            r_q   <= w_idx;
                        end
                        if (!r_used[w_idx] && !r_free_ok) begin
                            r_free_ok <= 1'b1;
                            r_free    <= w_idx;
                        end
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DISPATCH: begin
                    r_i     <= '0;
                    r_found <= 1'b0;
                    r_then_rm <= 1'b0;
                    if (r_cmd.kind == ipcmq_pkg::K_CREATE) begin
                        r_state <= S_RSP;
                        if (r_hit || r_free_ok) begin
                            r_used[r_hit ? r_q : r_free]  <= 1'b1;
                            r_key[r_hit ? r_q : r_free]   <= r_cmd.queue_key;
                            r_head[r_hit ? r_q : r_free]  <= '0;
                            r_rcnt[r_hit ? r_q : r_free]  <= '0;
                            r_wrcnt[r_hit ? r_q : r_free] <= '0;
                            r_wscnt[r_hit ? r_q : r_free] <= '0;
                            r_gcnt[r_hit ? r_q : r_free]  <= '0;
                        end else begin
                            r_rsp.status <= ipcmq_pkg::ST_ERR;
                        end
                    end else if (r_cmd.kind inside {ipcmq_pkg::K_POP_SEND,
                            ipcmq_pkg::K_POP_RECV, ipcmq_pkg::K_GRANT_QRY}) begin
                        if (r_hit) begin
                            r_list  <= (r_cmd.kind == ipcmq_pkg::K_POP_SEND) ? L_SEND :
                                       (r_cmd.kind == ipcmq_pkg::K_POP_RECV) ? L_RECV :
                                       L_GRANT;
                            r_state <= (r_cmd.kind == ipcmq_pkg::K_GRANT_QRY) ? S_SCAN
                                                                             : S_RD;
                        end else begin
                            r_state <= S_RSP;
                        end
                    end else if (!r_hit && !r_free_ok) begin
                        r_rsp.status <= ipcmq_pkg::ST_ERR;
                        r_state      <= S_RSP;
                    end else begin
                        if (!r_hit) begin
                            r_used[r_free]  <= 1'b1;
                            r_key[r_free]   <= r_cmd.queue_key;
                            r_head[r_free]  <= '0;
                            r_rcnt[r_free]  <= '0;
                            r_wrcnt[r_free] <= '0;
                            r_wscnt[r_free] <= '0;
                            r_gcnt[r_free]  <= '0;
                            r_q             <= r_free;
                        end
                        r_list  <= (r_cmd.kind == ipcmq_pkg::K_SEND) ? L_RECV :
                                   (r_cmd.kind == ipcmq_pkg::K_ADD_SEND) ? L_SEND :
                                   (r_cmd.kind == ipcmq_pkg::K_ADD_RECV) ? L_RECV :
                                   L_GRANT;
                        r_state <= (r_cmd.kind == ipcmq_pkg::K_SEND) ? S_RD : S_SCAN;
                    end
                end
                // search the selected list for task_id: read, then compare
                S_SCAN: begin
                    if (r_i == w_cnt) begin
                        r_state <= r_rm ? S_RSP : S_RD;
                    end else begin
                        case (r_list)
                            L_RECV:  r_rd_id <= r_rlist[w_la];
                            L_SEND:  r_rd_id <= r_slist[w_la];
                            default: r_rd_id <= r_gown[w_la];
                        endcase
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_rd_id == r_cmd.task_id) begin
                        r_found <= 1'b1;
                        r_state <= r_rm ? S_SHIFT : S_RD;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_SCAN;
                    end
                end
                // registered reads of the located entries
                S_RD: begin
                    case (r_list)
                        L_RECV:  r_rd_id <= r_rlist[w_la];
                        L_SEND:  r_rd_id <= r_slist[w_la];
                        default: r_rd_id <= r_gown[w_la];
                    endcase
                    r_rd_msg  <= r_gmsg[w_la];
                    r_rd_r0   <= r_rlist[w_q0];
                    r_rd_ring <= r_msg[{r_q, r_head[r_q]}];
                    r_state   <= S_RD2;
                end
                S_RD2: begin
                    case (r_cmd.kind)
                        ipcmq_pkg::K_SEND: begin
                            r_state <= S_RSP;
                            if (r_wrcnt[r_q] != '0) begin
                                if (r_gcnt[r_q] == (WW+1)'(WD)) begin
                                    r_rsp.status <= ipcmq_pkg::ST_ERR;
                                end else begin
                                    r_gown[{r_q, r_gcnt[r_q][WW-1:0]}] <= r_rd_r0;
                                    r_gmsg[{r_q, r_gcnt[r_q][WW-1:0]}] <=
                                        {r_cmd.task_id, r_cmd.payload};
                                    r_gcnt[r_q] <= r_gcnt[r_q] + 1'b1;
                                end
                            end else if (r_rcnt[r_q] == (MW+1)'(MD)) begin
                                r_rsp.status <= ipcmq_pkg::ST_BLOCK;
                            end else begin
                                r_msg[SW'({r_q, MW'(r_head[r_q] + r_rcnt[r_q][MW-1:0])})]
                                    <= {r_cmd.task_id, r_cmd.payload};
                                r_rcnt[r_q] <= r_rcnt[r_q] + 1'b1;
                            end
                        end
                        ipcmq_pkg::K_RECV: begin
                            if (r_found) begin
                                r_rsp.msg_sender  <= r_rd_msg[39:32];
                                r_rsp.msg_payload <= r_rd_msg[31:0];
                                r_then_rm <= 1'b1;
                                r_state   <= S_SHIFT;
                            end else if ((r_wrcnt[r_q] != '0 && r_rd_r0 != r_cmd.task_id)
                                         || r_rcnt[r_q] == '0) begin
                                r_rsp.status <= ipcmq_pkg::ST_BLOCK;
                                r_state      <= S_RSP;
                            end else begin
                                r_rsp.msg_sender  <= r_rd_ring[39:32];
                                r_rsp.msg_payload <= r_rd_ring[31:0];
                                r_head[r_q] <= r_head[r_q] + 1'b1;
                                r_rcnt[r_q] <= r_rcnt[r_q] - 1'b1;
                                r_state     <= S_RSP;
                            end
                        end
                        ipcmq_pkg::K_ADD_SEND, ipcmq_pkg::K_ADD_RECV: begin
                            r_state <= S_RSP;
                            if (!r_found && w_cnt != (WW+1)'(WD)) begin
                                if (r_list == L_SEND) begin
                                    r_slist[{r_q, w_cnt[WW-1:0]}] <= r_cmd.task_id;
                                    r_wscnt[r_q] <= r_wscnt[r_q] + 1'b1;
                                end else begin
                                    r_rlist[{r_q, w_cnt[WW-1:0]}] <= r_cmd.task_id;
                                    r_wrcnt[r_q] <= r_wrcnt[r_q] + 1'b1;
                                end
                            end
                        end
                        ipcmq_pkg::K_POP_SEND, ipcmq_pkg::K_POP_RECV: begin
                            if (w_cnt != '0) begin
                                r_rsp.waiter_valid <= 1'b1;
                                r_rsp.waiter_id    <= r_rd_id;
                                r_state <= S_SHIFT;
                            end else begin
                                r_state <= S_RSP;
                            end
                        end
                        ipcmq_pkg::K_GRANT_QRY: begin
                            r_rsp.grant_present <= r_found;
                            r_state <= S_RSP;
                        end
                        default: r_state <= S_RSP;
                    endcase
                end
                // close the gap at r_i: read the next entry, then write it down
                S_SHIFT: begin
                    if (r_i + (WW+1)'(1) >= w_cnt) begin
                        case (r_list)
                            L_RECV:  r_wrcnt[r_q] <= r_wrcnt[r_q] - 1'b1;
                            L_SEND:  r_wscnt[r_q] <= r_wscnt[r_q] - 1'b1;
                            default: r_gcnt[r_q]  <= r_gcnt[r_q] - 1'b1;
                        endcase
                        r_state <= S_SHIFT2;
                    end else begin
                        case (r_list)
                            L_RECV:  r_rd_id <= r_rlist[w_lb];
                            L_SEND:  r_rd_id <= r_slist[w_lb];
                            default: r_rd_id <= r_gown[w_lb];
                        endcase
                        r_rd_msg <= r_gmsg[w_lb];
                        r_state  <= S_SHIFT_WR;
                    end
                end
                S_SHIFT_WR: begin
                    case (r_list)
                        L_RECV:  r_rlist[w_la] <= r_rd_id;
                        L_SEND:  r_slist[w_la] <= r_rd_id;
                        default: begin
                            r_gown[w_la] <= r_rd_id;
                            r_gmsg[w_la] <= r_rd_msg;
                        end
                    endcase
                    r_i     <= r_i + 1'b1;
                    r_state <= S_SHIFT;
                end
                // after a granted receive, remove the caller from the waiters
                S_SHIFT2: begin
                    if (r_then_rm) begin
                        r_then_rm <= 1'b0;
                        r_rm      <= 1'b1;
                        r_list    <= L_RECV;
                        r_i       <= '0;
                        r_found   <= 1'b0;
                        r_state   <= S_SCAN;
                    end else begin
                        r_state <= S_RSP;
                    end
                end
                S_RSP: begin
                    if (o_rsp.ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* tb/mailbox_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mailbox_checker: response predictor and comparator for the mailbox engine
// Watches both channels, runs its own copy of the queue table on every
// accepted command and compares each accepted response with the expected one.
// ----------------------------------------------------------------------------
module mailbox_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  logic            i_cmd_ready,
    input  ipcmq_pkg::t_cmd i_cmd_data,
    input  logic            i_rsp_valid,
    input  logic            i_rsp_ready,
    input  ipcmq_pkg::t_rsp i_rsp_data,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_hit_err,
    output int              o_hit_block,
    output int              o_hit_grant
);

    localparam int NUM_QUEUES = ipcmq_pkg::NUM_QUEUES;
    localparam int MSG_DEPTH  = ipcmq_pkg::MSG_DEPTH;
    localparam int WAIT_DEPTH = ipcmq_pkg::WAIT_DEPTH;

    typedef struct packed {
        logic [7:0]  sender;
        logic [31:0] value;
    } t_msg;

    logic             mb_used   [NUM_QUEUES];
    logic [15:0]      mb_key    [NUM_QUEUES];
    int               mb_head   [NUM_QUEUES];
    int               mb_count  [NUM_QUEUES];
    t_msg             mb_ring   [NUM_QUEUES][MSG_DEPTH];
    logic [7:0]       rw_list   [NUM_QUEUES][WAIT_DEPTH];
    int               rw_count  [NUM_QUEUES];
    logic [7:0]       sw_list   [NUM_QUEUES][WAIT_DEPTH];
    int               sw_count  [NUM_QUEUES];
    logic [7:0]       gr_owner  [NUM_QUEUES][WAIT_DEPTH];
    t_msg             gr_msg    [NUM_QUEUES][WAIT_DEPTH];
    int               gr_count  [NUM_QUEUES];

    ipcmq_pkg::t_rsp expected_rsp_q[$];

    function automatic int lookup_slot(logic [15:0] key);
        for (int i = 0; i < NUM_QUEUES; i++)
            if (mb_used[i] && mb_key[i] == key) return i;
        return -1;
    endfunction

    function automatic void open_queue(int q, logic [15:0] key);
        mb_used[q] = 1'b1;
        mb_key[q] = key;
        mb_head[q] = 0;
        mb_count[q] = 0;
        rw_count[q] = 0;
        sw_count[q] = 0;
        gr_count[q] = 0;
    endfunction

    function automatic int claim_queue(logic [15:0] key);
        for (int i = 0; i < NUM_QUEUES; i++)
            if (!mb_used[i]) begin
                open_queue(i, key);
                return i;
            end
        return -1;
    endfunction

    function automatic int find_or_claim(logic [15:0] key);
        int q;
        q = lookup_slot(key);
        return (q >= 0) ? q : claim_queue(key);
    endfunction

    function automatic ipcmq_pkg::t_rsp mailbox_step(ipcmq_pkg::t_cmd c);
        ipcmq_pkg::t_rsp r;
        int   q;
        int   i;
        int   n;
        logic hit;
        r = '0;
        case (ipcmq_pkg::t_kind'(c.kind))
            ipcmq_pkg::K_CREATE: begin
                q = lookup_slot(c.queue_key);
                if (q >= 0) open_queue(q, c.queue_key);
                else if (claim_queue(c.queue_key) < 0) r.status = ipcmq_pkg::ST_ERR;
            end
            ipcmq_pkg::K_SEND: begin
                q = find_or_claim(c.queue_key);
                if (q < 0) begin
                    r.status = ipcmq_pkg::ST_ERR;
                end else if (rw_count[q] > 0) begin
                    n = gr_count[q];
                    if (n >= WAIT_DEPTH) r.status = ipcmq_pkg::ST_ERR;
                    else begin
                        gr_owner[q][n] = rw_list[q][0];
                        gr_msg[q][n] = {c.task_id, c.payload};
                        gr_count[q] = n + 1;
                    end
                end else if (mb_count[q] >= MSG_DEPTH) begin
                    r.status = ipcmq_pkg::ST_BLOCK;
                end else begin
                    mb_ring[q][(mb_head[q] + mb_count[q]) % MSG_DEPTH] =
                        {c.task_id, c.payload};
                    mb_count[q]++;
                end
            end
            ipcmq_pkg::K_RECV: begin
                q = find_or_claim(c.queue_key);
                if (q < 0) begin
                    r.status = ipcmq_pkg::ST_ERR;
                end else begin
                    hit = 1'b0;
                    for (i = 0; i < gr_count[q]; i++)
                        if (gr_owner[q][i] == c.task_id) begin
                            hit = 1'b1;
                            break;
                        end
                    if (hit) begin
                        {r.msg_sender, r.msg_payload} = gr_msg[q][i];
                        for (int j = i + 1; j < gr_count[q]; j++) begin
                            gr_owner[q][j-1] = gr_owner[q][j];
                            gr_msg[q][j-1] = gr_msg[q][j];
                        end
                        gr_count[q]--;
                        // drop the first matching receiver waiter
                        for (int k = 0; k < rw_count[q]; k++)
                            if (rw_list[q][k] == c.task_id) begin
                                for (int j = k + 1; j < rw_count[q]; j++)
                                    rw_list[q][j-1] = rw_list[q][j];
                                rw_count[q]--;
                                break;
                            end
                    end else if (rw_count[q] > 0 && rw_list[q][0] != c.task_id) begin
                        r.status = ipcmq_pkg::ST_BLOCK;
                    end else if (mb_count[q] == 0) begin
                        r.status = ipcmq_pkg::ST_BLOCK;
                    end else begin
                        {r.msg_sender, r.msg_payload} = mb_ring[q][mb_head[q]];
                        mb_head[q] = (mb_head[q] + 1) % MSG_DEPTH;
                        mb_count[q]--;
                    end
                end
            end
            ipcmq_pkg::K_ADD_SEND, ipcmq_pkg::K_ADD_RECV: begin
                q = find_or_claim(c.queue_key);
                if (q < 0) r.status = ipcmq_pkg::ST_ERR;
                else if (ipcmq_pkg::t_kind'(c.kind) == ipcmq_pkg::K_ADD_SEND) begin
                    hit = 1'b0;
                    for (i = 0; i < sw_count[q]; i++)
                        if (sw_list[q][i] == c.task_id) hit = 1'b1;
                    if (!hit && sw_count[q] < WAIT_DEPTH) begin
                        sw_list[q][sw_count[q]] = c.task_id;
                        sw_count[q]++;
                    end
                end else begin
                    hit = 1'b0;
                    for (i = 0; i < rw_count[q]; i++)
                        if (rw_list[q][i] == c.task_id) hit = 1'b1;
                    if (!hit && rw_count[q] < WAIT_DEPTH) begin
                        rw_list[q][rw_count[q]] = c.task_id;
                        rw_count[q]++;
                    end
                end
            end
            ipcmq_pkg::K_POP_SEND: begin
                q = lookup_slot(c.queue_key);
                if (q >= 0 && sw_count[q] > 0) begin
                    r.waiter_valid = 1'b1;
                    r.waiter_id = sw_list[q][0];
                    for (i = 1; i < sw_count[q]; i++) sw_list[q][i-1] = sw_list[q][i];
                    sw_count[q]--;
                end
            end
            ipcmq_pkg::K_POP_RECV: begin
                q = lookup_slot(c.queue_key);
                if (q >= 0 && rw_count[q] > 0) begin
                    r.waiter_valid = 1'b1;
                    r.waiter_id = rw_list[q][0];
                    for (i = 1; i < rw_count[q]; i++) rw_list[q][i-1] = rw_list[q][i];
                    rw_count[q]--;
                end
            end
            default: begin
                q = lookup_slot(c.queue_key);
                if (q >= 0)
                    for (i = 0; i < gr_count[q]; i++)
                        if (gr_owner[q][i] == c.task_id) r.grant_present = 1'b1;
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        ipcmq_pkg::t_rsp exp_rsp;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                mb_used[i] = 1'b0;
                mb_key[i] = '0;
                mb_head[i] = 0;
                mb_count[i] = 0;
                rw_count[i] = 0;
                sw_count[i] = 0;
                gr_count[i] = 0;
            end
            expected_rsp_q.delete();
            o_fail_count <= 0;
            o_hit_err <= 0;
            o_hit_block <= 0;
            o_hit_grant <= 0;
        end else begin
            if (i_cmd_valid && i_cmd_ready) begin
                exp_rsp = mailbox_step(i_cmd_data);
                if (exp_rsp.status == ipcmq_pkg::ST_ERR) o_hit_err <= o_hit_err + 1;
                if (exp_rsp.status == ipcmq_pkg::ST_BLOCK) o_hit_block <= o_hit_block + 1;
                if (exp_rsp.grant_present) o_hit_grant <= o_hit_grant + 1;
                expected_rsp_q.push_back(exp_rsp);
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_rsp_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("[%0t] response with nothing expected: %p", $realtime,
                                 i_rsp_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_rsp = expected_rsp_q.pop_front();
                    if (i_rsp_data !== exp_rsp) begin
                        if (o_fail_count < 10)
                            $display("[%0t] mismatch: expected %p, got %p", $realtime,
                                     exp_rsp, i_rsp_data);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= expected_rsp_q.size();
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the mailbox queue engine
// Directed commands hit table-full, ring-full, grant-full and waiter cases,
// then random sequences on a small key set with random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;

    localparam int N_RANDOM   = 1880;
    localparam int IDLE_LIMIT = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ipcmq_cmd_if cmd_ch ();
    ipcmq_rsp_if rsp_ch ();

    int  fail_count, pending, hit_err, hit_block, hit_grant;
    int  sent_count = 0;
    int  idle_cycles = 0;
    bit  calm_tail = 1'b0;
    bit  hold_rsp = 1'b0;
    logic [15:0] key_pool [8];

    always #2 i_clk = ~i_clk;

    ipc_mailbox_queue_engine u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    mailbox_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (cmd_ch.valid),
        .i_cmd_ready  (cmd_ch.ready),
        .i_cmd_data   (cmd_ch.data),
        .i_rsp_valid  (rsp_ch.valid),
        .i_rsp_ready  (rsp_ch.ready),
        .i_rsp_data   (rsp_ch.data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_hit_err    (hit_err),
        .o_hit_block  (hit_block),
        .o_hit_grant  (hit_grant)
    );

    // receiver: random stall bursts, plus a long hold requested by stimulus
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_rsp) begin
                rsp_ch.ready <= 1'b0;
                repeat (300) @(negedge i_clk);
                rsp_ch.ready <= 1'b1;
                hold_rsp = 1'b0;
            end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 3)) @(negedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // count cycles without any handshake
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("watchdog expired with %0d responses outstanding", pending);
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic send_cmd(ipcmq_pkg::t_kind kind, logic [15:0] key, logic [7:0] tid,
                            logic [31:0] pay);
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= '{kind: kind, queue_key: key, task_id: tid, payload: pay};
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        sent_count++;
        if (!calm_tail && $urandom_range(0, 4) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
    endtask

    task automatic drain_responses();
        cmd_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic ipcmq_pkg::t_kind pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)  return ipcmq_pkg::K_CREATE;
        if (r < 33) return ipcmq_pkg::K_SEND;
        if (r < 60) return ipcmq_pkg::K_RECV;
        if (r < 67) return ipcmq_pkg::K_ADD_SEND;
        if (r < 80) return ipcmq_pkg::K_ADD_RECV;
        if (r < 85) return ipcmq_pkg::K_POP_SEND;
        if (r < 90) return ipcmq_pkg::K_POP_RECV;
        return ipcmq_pkg::K_GRANT_QRY;
    endfunction

    initial begin
        ipcmq_pkg::t_kind k;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // probe absent keys, fill the table with extreme keys, then one more create and a send to a new key fail
        send_cmd(ipcmq_pkg::K_GRANT_QRY, 16'hFFFF, 8'hFF, 32'h0);
        send_cmd(ipcmq_pkg::K_POP_SEND, 16'h0000, 8'h00, 32'h0);
        for (int i = 0; i < ipcmq_pkg::NUM_QUEUES; i++)
            send_cmd(ipcmq_pkg::K_CREATE, (i == 0) ? 16'h0000 : 16'(16'hFFFF - i + 1),
                     8'(i), 32'h0);
        send_cmd(ipcmq_pkg::K_CREATE, 16'h1234, 8'h01, 32'h0);
        send_cmd(ipcmq_pkg::K_SEND, 16'h4321, 8'hFF, 32'h7FFFFFFF);
        // ring full on key 0 with extreme payloads, then one receive
        for (int i = 0; i <= ipcmq_pkg::MSG_DEPTH; i++)
            send_cmd(ipcmq_pkg::K_SEND, 16'h0000, 8'(i),
                     (i & 1) ? 32'h80000000 : 32'hFFFFFFFF);
        send_cmd(ipcmq_pkg::K_RECV, 16'h0000, 8'hAA, 32'h0);
        // grants: receiver waits, sends grant until overflow, query, receives
        send_cmd(ipcmq_pkg::K_CREATE, 16'hFFFF, 8'h00, 32'h0);
        send_cmd(ipcmq_pkg::K_ADD_RECV, 16'hFFFF, 8'h55, 32'h0);
        send_cmd(ipcmq_pkg::K_ADD_RECV, 16'hFFFF, 8'h55, 32'h0);
        for (int i = 0; i <= ipcmq_pkg::WAIT_DEPTH; i++)
            send_cmd(ipcmq_pkg::K_SEND, 16'hFFFF, 8'hC3, 32'(i));
        send_cmd(ipcmq_pkg::K_GRANT_QRY, 16'hFFFF, 8'h55, 32'h0);
        send_cmd(ipcmq_pkg::K_RECV, 16'hFFFF, 8'h01, 32'h0);
        send_cmd(ipcmq_pkg::K_RECV, 16'hFFFF, 8'h55, 32'h0);
        drain_responses();

        // the table stays full: create only resets a slot and never frees one, so work
        // random traffic on the keys already present plus some misses
        for (int i = 0; i < 8; i++)
            key_pool[i] = (i == 0) ? 16'h0000 : 16'(16'hFFFF - i + 1);
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 600) begin
                hold_rsp = 1'b1;
            end
            if (n == 1000) drain_responses();
            if (n == N_RANDOM - 150) calm_tail = 1'b1;
            k = pick_kind();
            send_cmd(k,
                     ($urandom_range(0, 19) == 0) ? 16'($urandom) :
                         key_pool[$urandom_range(0, 7)],
                     ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3)),
                     $urandom);
        end
        drain_responses();
        repeat (40) @(negedge i_clk);

        $display("commands sent: %0d, status error %0d, would block %0d, grants seen %0d",
                 sent_count, hit_err, hit_block, hit_grant);
        if (fail_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/ipcmq_pkg.sv
rtl/ipcmq_if.sv
rtl/ipc_mailbox_queue_engine.sv
tb/mailbox_checker.sv
tb/testbench.sv
